@@ hw/rtl/psfd_pkg.sv @@
// ----------------------------------------------------------------------------
// psfd_pkg
// Shared types and constants of the PPM sum frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package psfd_pkg;

   localparam int SLOTS_DEF     = 10;
   localparam int TIME_BITS_DEF = 32;
   localparam int QUEUE_DEPTH   = 2;

   localparam int CFG_W   = 16;
   localparam int WIDTH_W = 16;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 4;
   localparam int ERR_W   = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [ERR_W-1:0]   ERR_MAX       = 8'd255;
   localparam logic [WIDTH_W-1:0] PENDING_RESET = 16'd1500;

   localparam logic [CFG_W-1:0] SYNC_GAP_MIN_RST = 16'd4000;
   localparam logic [CFG_W-1:0] SYNC_GAP_MAX_RST = 16'd21000;
   localparam logic [CFG_W-1:0] BAD_ABOVE_RST    = 16'd2400;
   localparam logic [CFG_W-1:0] BAD_BELOW_RST    = 16'd650;
   localparam logic [CFG_W-1:0] GOOD_MIN_RST     = 16'd900;
   localparam logic [CFG_W-1:0] GOOD_MAX_RST     = 16'd2100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_GAP_MIN = 3'd0,
      CSR_SYNC_GAP_MAX = 3'd1,
      CSR_BAD_ABOVE    = 3'd2,
      CSR_BAD_BELOW    = 3'd3,
      CSR_GOOD_MIN     = 3'd4,
      CSR_GOOD_MAX     = 3'd5
   } csr_idx_type;

   typedef enum logic {
      KIND_PULSE  = 1'b0,
      KIND_COMMIT = 1'b1
   } kind_type;

   // one classified edge, handed from front to back
   typedef struct packed {
      logic                 commit;
      logic                 stored;
      logic [SLOT_W-1:0]    slot;
      logic [WIDTH_W-1:0]   width;
      logic [COUNT_W-1:0]   valid_count;
      logic                 in_sync;
      logic                 error_seen;
   } cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/ppm_sum_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// ppm_sum_frame_decoder
// Decodes PPM sum frames from a stream of rising-edge timestamps.
// ----------------------------------------------------------------------------
// req_*  : one transfer per edge; req_tdata carries the edge timestamp.
// rsp_*  : per edge, SLOTS committed slot values (tuser=1) when a clean sync
//          gap closes a frame, then one pulse report (tuser=0, tlast=1).
// csr_*  : register writes, taken every cycle; write only while idle.
// Path: the edge is measured into the interval register, classified and
//   pushed to the queue, then loaded into the result register (rsp_tvalid).
// The front holds one edge until it has pushed it; a full queue stalls it.
// The back emits one result per cycle while the queue holds a command and
//   rsp_tready takes the held result, if any; a commit edge gives SLOTS+1 results.
// The 2-entry queue between them lets the front go on while a result waits.
// Reset: registers load their defaults, timestamp and counters clear, all
//   pending slots read as 1500 until written.
// rsp_tready low holds the result register; the queue then fills and
//   req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_sum_frame_decoder #(
   parameter int SLOTS     = psfd_pkg::SLOTS_DEF,
   parameter int TIME_BITS = psfd_pkg::TIME_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [((TIME_BITS+7)/8)*8-1:0] req_tdata,   // edge_time
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [31:0]                    rsp_tdata,   // slot, width, stored,
                                                            // valid_count, in_sync, error_seen
   output      logic                           rsp_tuser,   // kind
   output      logic                           rsp_tlast,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [psfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [psfd_pkg::CFG_W-1:0]     csr_wdata
);

   logic              q_full, q_push, q_empty, q_pop;
   psfd_pkg::cmd_type q_cmd, q_head;

   assign csr_ready = 1'b1;

   psfd_front #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .edge_time  (req_tdata[TIME_BITS-1:0]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   psfd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   psfd_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ hw/rtl/psfd_front.sv @@
// ----------------------------------------------------------------------------
// psfd_front
// Config registers, interval measurement and frame classification.
// ----------------------------------------------------------------------------
`default_nettype none

module psfd_front #(
   parameter int SLOTS     = psfd_pkg::SLOTS_DEF,
   parameter int TIME_BITS = psfd_pkg::TIME_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [TIME_BITS-1:0]           edge_time,
   input  wire logic                           csr_valid,
   input  wire logic [psfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [psfd_pkg::CFG_W-1:0]     csr_wdata,
   input  wire logic                           q_full,
   output      logic                           q_push,
   output      psfd_pkg::cmd_type              q_cmd
);

   localparam int CNT_W = $clog2(SLOTS + 1);

   logic [psfd_pkg::CFG_W-1:0] sync_min_ff, sync_max_ff, bad_above_ff;
   logic [psfd_pkg::CFG_W-1:0] bad_below_ff, good_min_ff, good_max_ff;

   logic                       busy_ff;
   logic [TIME_BITS-1:0]       prev_ff;
   logic [TIME_BITS-1:0]       diff_ff;
   logic [CNT_W-1:0]           slot_ff, slot_in;
   logic                       sync_ff, sync_in;
   logic [psfd_pkg::ERR_W-1:0] err_ff, err_in;
   logic [CNT_W-1:0]           good_ff, good_in;

   logic             is_sync, is_bad, is_good;
   logic             commit, store;
   logic [CNT_W-1:0] st_slot;

   assign req_tready = !busy_ff;
   assign q_push     = busy_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_min_ff  <= psfd_pkg::SYNC_GAP_MIN_RST;
         sync_max_ff  <= psfd_pkg::SYNC_GAP_MAX_RST;
         bad_above_ff <= psfd_pkg::BAD_ABOVE_RST;
         bad_below_ff <= psfd_pkg::BAD_BELOW_RST;
         good_min_ff  <= psfd_pkg::GOOD_MIN_RST;
         good_max_ff  <= psfd_pkg::GOOD_MAX_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            psfd_pkg::CSR_SYNC_GAP_MIN: sync_min_ff  <= csr_wdata;
            psfd_pkg::CSR_SYNC_GAP_MAX: sync_max_ff  <= csr_wdata;
            psfd_pkg::CSR_BAD_ABOVE:    bad_above_ff <= csr_wdata;
            psfd_pkg::CSR_BAD_BELOW:    bad_below_ff <= csr_wdata;
            psfd_pkg::CSR_GOOD_MIN:     good_min_ff  <= csr_wdata;
            psfd_pkg::CSR_GOOD_MAX:     good_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      is_sync = (diff_ff > TIME_BITS'(sync_min_ff)) && (diff_ff < TIME_BITS'(sync_max_ff));
      is_bad  = (diff_ff > TIME_BITS'(bad_above_ff)) || (diff_ff < TIME_BITS'(bad_below_ff));
      is_good = (diff_ff <= TIME_BITS'(good_max_ff)) && (diff_ff >= TIME_BITS'(good_min_ff));
      slot_in = slot_ff;
      sync_in = sync_ff;
      err_in  = err_ff;
      good_in = good_ff;
      commit  = 1'b0;
      store   = 1'b0;
      st_slot = '0;
      if (is_sync) begin
         slot_in = '0;
         good_in = '0;
         commit  = (err_ff == '0);
         sync_in = 1'b1;
         err_in  = '0;
      end else if (is_bad && err_ff != psfd_pkg::ERR_MAX) begin
         err_in = err_ff + 1'b1;
      end
      if (sync_in && slot_in < CNT_W'(SLOTS)) begin
         store   = 1'b1;
         st_slot = slot_in;
         slot_in = slot_in + 1'b1;
         if (is_good) begin
            good_in = good_in + 1'b1;
         end
      end
      if (slot_in >= CNT_W'(SLOTS)) begin
         sync_in = 1'b0;
         good_in = '0;
      end
   end

   always_comb begin
      q_cmd.commit      = commit;
      q_cmd.stored      = store;
      q_cmd.slot        = psfd_pkg::SLOT_W'(st_slot);
      q_cmd.width       = diff_ff[psfd_pkg::WIDTH_W-1:0];
      q_cmd.valid_count = psfd_pkg::COUNT_W'(good_in);
      q_cmd.in_sync     = sync_in;
      q_cmd.error_seen  = (err_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prev_ff <= '0;
         slot_ff <= '0;
         sync_ff <= 1'b0;
         err_ff  <= '0;
         good_ff <= '0;
      end else begin
         if (req_tvalid && !busy_ff) begin
            busy_ff <= 1'b1;
            prev_ff <= edge_time;
         end else if (q_push) begin
            busy_ff <= 1'b0;
            slot_ff <= slot_in;
            sync_ff <= sync_in;
            err_ff  <= err_in;
            good_ff <= good_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && !busy_ff) begin
         diff_ff <= edge_time - prev_ff;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/psfd_fifo.sv @@
// ----------------------------------------------------------------------------
// psfd_fifo
// Short command queue between classifier and result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module psfd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire psfd_pkg::cmd_type push_cmd,
   output      logic              full,
   input  wire logic              pop,
   output      logic              empty,
   output      psfd_pkg::cmd_type head
);

   localparam int DEPTH = psfd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   psfd_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/psfd_back.sv @@
// ----------------------------------------------------------------------------
// psfd_back
// Slot store and result sequencer: committed slots, then the pulse report.
// ----------------------------------------------------------------------------
`default_nettype none

module psfd_back #(
   parameter int SLOTS = psfd_pkg::SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire psfd_pkg::cmd_type q_head,
   output      logic              q_pop,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [31:0]       rsp_tdata,   // slot, width, stored, valid_count, in_sync, error_seen
   output      logic              rsp_tuser,   // kind
   output      logic              rsp_tlast
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   logic [psfd_pkg::WIDTH_W-1:0] pend_ff [SLOTS];
   logic [SLOTS-1:0]             pend_vld_ff;
   logic [CNT_W-1:0]             cidx_ff;

   logic                         out_valid_ff;
   logic                         out_kind_ff, out_last_ff, out_stored_ff;
   logic [psfd_pkg::SLOT_W-1:0]  out_slot_ff;
   logic [psfd_pkg::WIDTH_W-1:0] out_width_ff;
   logic [psfd_pkg::COUNT_W-1:0] out_vc_ff;
   logic                         out_sync_ff, out_err_ff;

   logic                         load, in_commit;
   logic [IDX_W-1:0]             ridx, widx;
   logic [psfd_pkg::WIDTH_W-1:0] rdata;

   assign load      = !q_empty && (!out_valid_ff || rsp_tready);
   assign in_commit = q_head.commit && (cidx_ff < CNT_W'(SLOTS));
   assign q_pop     = load && !in_commit;
   assign ridx      = cidx_ff[IDX_W-1:0];
   assign widx      = q_head.slot[IDX_W-1:0];
   assign rdata     = pend_vld_ff[ridx] ? pend_ff[ridx] : psfd_pkg::PENDING_RESET;

   always_ff @(posedge clock) begin
      if (q_pop && q_head.stored) begin
         pend_ff[widx] <= q_head.width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff  <= '0;
         cidx_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop && q_head.stored) begin
            pend_vld_ff[widx] <= 1'b1;
         end
         if (load) begin
            cidx_ff <= in_commit ? cidx_ff + 1'b1 : '0;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_vc_ff   <= q_head.valid_count;
         out_sync_ff <= q_head.in_sync;
         out_err_ff  <= q_head.error_seen;
         if (in_commit) begin
            out_kind_ff   <= psfd_pkg::KIND_COMMIT;
            out_slot_ff   <= psfd_pkg::SLOT_W'(cidx_ff);
            out_width_ff  <= rdata;
            out_stored_ff <= 1'b0;
            out_last_ff   <= 1'b0;
         end else begin
            out_kind_ff   <= psfd_pkg::KIND_PULSE;
            out_slot_ff   <= q_head.slot;
            out_width_ff  <= q_head.width;
            out_stored_ff <= q_head.stored;
            out_last_ff   <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'd0, out_err_ff, out_sync_ff, out_vc_ff, out_stored_ff,
                        out_width_ff, out_slot_ff};

endmodule

`default_nettype wire

@@ hw/rtl/psfd_checker.sv @@
// ----------------------------------------------------------------------------
// psfd_checker
// Port-level checks on the result stream of the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module psfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_commit_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && !rsp_tdata[20])
      else $error("committed value marked last or stored");

   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("pulse report not last");

   a_unstored_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && !rsp_tdata[20] |-> rsp_tdata[3:0] == 4'd0)
      else $error("unstored pulse reports a slot");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind ppm_sum_frame_decoder psfd_checker u_psfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ test/ppm_sum_frame_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// ppm_sum_frame_decoder_tb
// Self-checking bench for the PPM sum frame decoder. Edge timestamps are
// streamed in. A local predictor mirrors the frame state (sync flag, slot
// position, error and valid counts, pending slot values) and queues the
// expected committed values and pulse reports, which are checked field by
// field in arrival order. Covers boundary intervals, timestamp wrap, register
// extremes, error saturation, long output back-pressure and random frames
// under several idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ppm_sum_frame_decoder_tb;

   localparam int SLOTS       = psfd_pkg::SLOTS_DEF;
   localparam int NUM_CSR     = int'(psfd_pkg::CSR_GOOD_MAX) + 1;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      psfd_pkg::kind_type             kind;
      logic [psfd_pkg::SLOT_W-1:0]    slot;
      logic [psfd_pkg::WIDTH_W-1:0]   width;
      logic                           stored;
      logic [psfd_pkg::COUNT_W-1:0]   valid_count;
      logic                           in_sync;
      logic                           error_seen;
      logic                           last;
   } ppm_result_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [31:0]                    req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [31:0]                    rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [psfd_pkg::CSR_IDX_W-1:0] csr_index  = psfd_pkg::CSR_SYNC_GAP_MIN;
   logic [psfd_pkg::CFG_W-1:0]     csr_wdata  = '0;

   // predictor state
   logic [psfd_pkg::CFG_W-1:0]     csr_shadow [NUM_CSR];
   logic [31:0]                    last_edge_us;
   int                             slot_count;
   int                             good_count;
   logic [psfd_pkg::ERR_W-1:0]     error_count;
   bit                             in_frame;
   logic [psfd_pkg::WIDTH_W-1:0]   pending_width [SLOTS];
   ppm_result_type                 expected_results [$];

   logic [31:0]                    edge_us;
   ppm_result_type                 want;
   int                             mismatch_count = 0;
   int                             cycle_count    = 0;
   int                             send_idle_pct  = 0;
   int                             recv_stall_pct = 0;
   int                             hold_left      = 0;
   bit                             hold_request   = 1'b0;

   ppm_sum_frame_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val) report_mismatch(what, got, exp_val);
   endtask

   function automatic void reset_model();
      csr_shadow[psfd_pkg::CSR_SYNC_GAP_MIN] = psfd_pkg::SYNC_GAP_MIN_RST;
      csr_shadow[psfd_pkg::CSR_SYNC_GAP_MAX] = psfd_pkg::SYNC_GAP_MAX_RST;
      csr_shadow[psfd_pkg::CSR_BAD_ABOVE]    = psfd_pkg::BAD_ABOVE_RST;
      csr_shadow[psfd_pkg::CSR_BAD_BELOW]    = psfd_pkg::BAD_BELOW_RST;
      csr_shadow[psfd_pkg::CSR_GOOD_MIN]     = psfd_pkg::GOOD_MIN_RST;
      csr_shadow[psfd_pkg::CSR_GOOD_MAX]     = psfd_pkg::GOOD_MAX_RST;
      last_edge_us = '0;
      slot_count   = 0;
      good_count   = 0;
      error_count  = '0;
      in_frame     = 1'b0;
      foreach (pending_width[i]) pending_width[i] = psfd_pkg::PENDING_RESET;
      edge_us = '0;
   endfunction

   // frame state update for one edge; queues committed values then the pulse report
   function automatic void predict_edge(input logic [31:0] now);
      logic [31:0]                  interval;
      logic [psfd_pkg::WIDTH_W-1:0] w16;
      logic [psfd_pkg::WIDTH_W-1:0] committed [SLOTS];
      bit                           do_commit;
      bit                           was_stored;
      int                           at_slot;
      ppm_result_type               r;
      interval     = now - last_edge_us;
      w16          = interval[psfd_pkg::WIDTH_W-1:0];
      last_edge_us = now;
      do_commit    = 1'b0;
      was_stored   = 1'b0;
      at_slot      = 0;
      if (interval > csr_shadow[psfd_pkg::CSR_SYNC_GAP_MIN] &&
          interval < csr_shadow[psfd_pkg::CSR_SYNC_GAP_MAX]) begin
         slot_count = 0;
         good_count = 0;
         if (error_count == 0) begin
            do_commit = 1'b1;
            committed = pending_width;
         end
         in_frame    = 1'b1;
         error_count = '0;
      end else if (interval > csr_shadow[psfd_pkg::CSR_BAD_ABOVE] ||
                   interval < csr_shadow[psfd_pkg::CSR_BAD_BELOW]) begin
         if (error_count != psfd_pkg::ERR_MAX) error_count++;
      end
      if (in_frame && slot_count < SLOTS) begin
         pending_width[slot_count] = w16;
         was_stored = 1'b1;
         at_slot    = slot_count;
         slot_count++;
         if (interval <= csr_shadow[psfd_pkg::CSR_GOOD_MAX] &&
             interval >= csr_shadow[psfd_pkg::CSR_GOOD_MIN])
            good_count++;
      end
      if (slot_count >= SLOTS) begin
         in_frame   = 1'b0;
         good_count = 0;
      end
      r.valid_count = psfd_pkg::COUNT_W'(good_count);
      r.in_sync     = in_frame;
      r.error_seen  = (error_count != 0);
      r.stored      = 1'b0;
      r.last        = 1'b0;
      r.kind        = psfd_pkg::KIND_COMMIT;
      if (do_commit) begin
         for (int i = 0; i < SLOTS; i++) begin
            r.slot  = psfd_pkg::SLOT_W'(i);
            r.width = committed[i];
            expected_results.push_back(r);
         end
      end
      r.kind   = psfd_pkg::KIND_PULSE;
      r.slot   = was_stored ? psfd_pkg::SLOT_W'(at_slot) : '0;
      r.width  = w16;
      r.stored = was_stored;
      r.last   = 1'b1;
      expected_results.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, tdata", rsp_tdata, 0);
         end else begin
            want = expected_results.pop_front();
            check_field("kind",        32'(rsp_tuser),        32'(want.kind));
            check_field("slot",        32'(rsp_tdata[3:0]),   32'(want.slot));
            check_field("width",       32'(rsp_tdata[19:4]),  32'(want.width));
            check_field("stored",      32'(rsp_tdata[20]),    32'(want.stored));
            check_field("valid_count", 32'(rsp_tdata[24:21]), 32'(want.valid_count));
            check_field("in_sync",     32'(rsp_tdata[25]),    32'(want.in_sync));
            check_field("error_seen",  32'(rsp_tdata[26]),    32'(want.error_seen));
            check_field("last",        32'(rsp_tlast),        32'(want.last));
         end
      end
   end

   // output side: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // leaves req_tvalid high; drain_outputs, or an idle step in the next call, lowers it
   task automatic send_edge(input logic [31:0] t_us);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t_us;
      edge_us = t_us;
      do @(posedge clock); while (!req_tready);
      predict_edge(t_us);
      @(negedge clock);
   endtask

   task automatic send_gap(input logic [31:0] gap_us);
      send_edge(edge_us + gap_us);
   endtask

   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_put(input logic [psfd_pkg::CSR_IDX_W-1:0] idx,
                          input logic [psfd_pkg::CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_CSR) csr_shadow[idx] = value;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [psfd_pkg::CFG_W-1:0] sync_min, sync_max,
                                 bad_hi, bad_lo, good_lo, good_hi);
      drain_outputs();
      csr_put(psfd_pkg::CSR_SYNC_GAP_MIN, sync_min);
      csr_put(psfd_pkg::CSR_SYNC_GAP_MAX, sync_max);
      csr_put(psfd_pkg::CSR_BAD_ABOVE,    bad_hi);
      csr_put(psfd_pkg::CSR_BAD_BELOW,    bad_lo);
      csr_put(psfd_pkg::CSR_GOOD_MIN,     good_lo);
      csr_put(psfd_pkg::CSR_GOOD_MAX,     good_hi);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_default_settings();
      apply_settings(psfd_pkg::SYNC_GAP_MIN_RST, psfd_pkg::SYNC_GAP_MAX_RST,
                     psfd_pkg::BAD_ABOVE_RST, psfd_pkg::BAD_BELOW_RST,
                     psfd_pkg::GOOD_MIN_RST, psfd_pkg::GOOD_MAX_RST);
   endtask

   task automatic apply_jittered_settings();
      apply_settings(psfd_pkg::CFG_W'($urandom_range(3000, 5000)),
                     psfd_pkg::CFG_W'($urandom_range(15000, 25000)),
                     psfd_pkg::CFG_W'($urandom_range(2200, 2600)),
                     psfd_pkg::CFG_W'($urandom_range(500, 800)),
                     psfd_pkg::CFG_W'($urandom_range(850, 1000)),
                     psfd_pkg::CFG_W'($urandom_range(2000, 2200)));
   endtask

   function automatic logic [31:0] sync_gap();
      if (csr_shadow[psfd_pkg::CSR_SYNC_GAP_MIN] + 1 < csr_shadow[psfd_pkg::CSR_SYNC_GAP_MAX])
         return $urandom_range(csr_shadow[psfd_pkg::CSR_SYNC_GAP_MIN] + 1,
                               csr_shadow[psfd_pkg::CSR_SYNC_GAP_MAX] - 1);
      return $urandom_range(0, 70000);
   endfunction

   function automatic logic [31:0] pulse_gap();
      if ($urandom_range(0, 99) < 8) return $urandom_range(0, 30000);
      if (csr_shadow[psfd_pkg::CSR_GOOD_MIN] <= csr_shadow[psfd_pkg::CSR_GOOD_MAX])
         return $urandom_range(csr_shadow[psfd_pkg::CSR_GOOD_MIN],
                               csr_shadow[psfd_pkg::CSR_GOOD_MAX]);
      return $urandom_range(0, 3000);
   endfunction

   // mostly sync gap plus a frame of pulses, some raw timestamps and short/long frames
   task automatic send_random_traffic(input int n_items);
      int sent;
      int n_pulses;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 12) begin
            send_edge($urandom());
            sent++;
         end else begin
            send_gap(sync_gap());
            n_pulses = ($urandom_range(0, 99) < 80) ? SLOTS - 1 : $urandom_range(0, SLOTS + 2);
            repeat (n_pulses) send_gap(pulse_gap());
            sent += n_pulses + 1;
         end
      end
   endtask

   task automatic test_directed();
      send_gap(5000);               // first edge, measured from zero; commits reset values
      send_gap(900);
      send_gap(2100);
      send_gap(899);
      send_gap(2101);
      send_gap(650);
      send_gap(649);
      send_gap(2400);
      send_gap(2401);
      send_gap(1500);               // tenth slot, frame closes
      send_gap(1500);               // not stored
      send_gap(4000);               // window edge, not a sync
      send_gap(4001);               // sync after error, no commit
      send_gap(1200);
      send_gap(20999);              // restart mid-frame, clean so it commits
      send_gap(21000);
      send_gap(32'h0001_1388);      // wide interval, low half stored
      send_gap(32'hFFFF_FFFF);
      send_edge(32'hFFFF_FFFF);
      send_edge(32'h0000_0000);     // wraps
      send_edge(32'h0000_0000);     // zero interval
      send_gap(6000);
      repeat (SLOTS - 1) send_gap(1500);
      send_gap(6000);
      drain_outputs();
   endtask

   task automatic test_register_extremes();
      apply_settings('0, '0, '0, '0, '0, '0);
      send_gap(0);
      send_gap(1);
      send_gap(65535);
      send_gap(70000);
      send_gap($urandom_range(0, 70000));
      apply_settings('1, '1, '1, '1, '1, '1);
      send_gap(65534);
      send_gap(65535);
      send_gap(65536);
      send_gap(0);
      send_gap(1);
      apply_settings('0, '1, '1, '0, '0, '1);
      send_gap(1);
      send_gap(65534);
      send_gap(65535);
      send_gap(0);
      send_gap(100);
      send_gap($urandom_range(1, 65534));
      drain_outputs();
      for (int i = NUM_CSR; i < 2 ** psfd_pkg::CSR_IDX_W; i++)
         csr_put(psfd_pkg::CSR_IDX_W'(i), psfd_pkg::CFG_W'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
      apply_default_settings();
      send_gap(5000);
      repeat (SLOTS - 1) send_gap(pulse_gap());
      send_gap(5000);
      drain_outputs();
   endtask

   task automatic test_error_saturation();
      apply_settings('0, '0, '0, '0, '0, '0);
      repeat (260) send_gap($urandom_range(1, 3000));
      apply_default_settings();
      send_gap(5000);
      repeat (SLOTS - 1) send_gap(1500);
      send_gap(5000);
      drain_outputs();
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      send_random_traffic(20);
      drain_outputs();
      send_random_traffic(10);
      drain_outputs();
   endtask

   task automatic test_random();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_default_settings();
      send_random_traffic(12);
      send_idle_pct  = 82;
      recv_stall_pct = 0;
      apply_jittered_settings();
      send_random_traffic(12);
      send_idle_pct  = 0;
      recv_stall_pct = 82;
      apply_jittered_settings();
      send_random_traffic(12);
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      apply_jittered_settings();
      send_random_traffic(12);
      apply_settings(psfd_pkg::CFG_W'($urandom_range(0, 65535)),
                     psfd_pkg::CFG_W'($urandom_range(0, 65535)),
                     psfd_pkg::CFG_W'($urandom_range(0, 65535)),
                     psfd_pkg::CFG_W'($urandom_range(0, 65535)),
                     psfd_pkg::CFG_W'($urandom_range(0, 65535)),
                     psfd_pkg::CFG_W'($urandom_range(0, 65535)));
      send_random_traffic(6);
      drain_outputs();
   endtask

   initial begin
      reset_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_register_extremes();
      test_error_saturation();
      test_backpressure();
      test_random();
      drain_outputs();
      repeat (20) @(negedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never produced", 0, expected_results.size());
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
